FILE: rtl/assert_macros.svh
// Assertion macros for the polynomial trapezoid integrator.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Overlapping implication on the rising clock edge, masked during reset.
`define PTI_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pti assertion failed");
// Next-cycle implication on the rising clock edge, masked during reset.
`define PTI_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pti assertion failed");
`else
`define PTI_ASSERT_IMP(name, cond, prop)
`define PTI_ASSERT_NXT(name, cond, prop)
`endif
`endif

FILE: rtl/pti_pkg.sv
// Shared types and constants of the polynomial trapezoid integrator.
// No dependencies; used by pti_mul and the top level.
`default_nettype none

package pti_pkg;

    localparam int NUM_COEF = 5;
    localparam int IDX_W    = $clog2(NUM_COEF);

    localparam logic [IDX_W-1:0] COEF_LIMIT = IDX_W'(NUM_COEF);
    localparam logic [IDX_W-1:0] K_FIRST    = IDX_W'(1);
    localparam logic [IDX_W-1:0] K_LAST     = IDX_W'(NUM_COEF - 1);

    // coef_x4 .. coef_x0 after reset: 8x^4 + 32x^3 + 40x^2 + 16x + 1
    localparam logic [31:0] COEF_RESET [NUM_COEF] = '{
        32'd524288, 32'd2097152, 32'd2621440, 32'd1048576, 32'd65536
    };

    localparam logic MODE_TRAP = 1'b0;
    localparam logic MODE_RECT = 1'b1;

    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic start;
        logic half;     // shift by 25 instead of 24
    } mul_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } mul_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/pti_div.sv
// Radix-2 restoring divider: signed 33-bit dividend by unsigned 16-bit divisor.
// Quotient truncates toward zero. Standalone; no package dependency.
`default_nettype none

module pti_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [32:0] dividend,
    input  wire logic        [15:0] divisor,
    output logic                    done,
    output logic signed [32:0]      quotient
);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t            state_reg;
    logic        [31:0] mag_reg;
    logic        [15:0] rem_reg;
    logic        [15:0] div_reg;
    logic               neg_reg;
    logic         [4:0] cnt_reg;
    logic               done_reg;
    logic signed [32:0] quot_reg;

    logic        [32:0] dvd_abs;
    logic        [16:0] rem_sh;
    logic        [17:0] diff;
    logic               ge;
    logic        [31:0] mag_next;
    logic        [32:0] quot_next;

    assign dvd_abs   = dividend[32] ? (~dividend + 33'd1) : dividend;
    assign rem_sh    = {rem_reg, mag_reg[31]};
    assign diff      = {1'b0, rem_sh} - {2'b00, div_reg};
    assign ge        = !diff[17];
    assign mag_next  = {mag_reg[30:0], ge};
    assign quot_next = neg_reg ? (~{1'b0, mag_next} + 33'd1) : {1'b0, mag_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            mag_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            quot_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        mag_reg   <= dvd_abs[31:0];
                        rem_reg   <= '0;
                        div_reg   <= divisor;
                        neg_reg   <= dividend[32];
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    // one quotient bit per cycle, MSB first
                    rem_reg <= ge ? diff[15:0] : rem_sh[15:0];
                    mag_reg <= mag_next;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        quot_reg  <= quot_next;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

FILE: rtl/pti_mul.sv
// Shared multiply-shift unit: trunc0(a * b / 2^24 or 2^25), saturated to 64 bits.
// One 32x32 multiplier used twice per operation. Depends on pti_pkg.
`default_nettype none

module pti_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pti_pkg::mul_req_t  req,
    input  wire logic signed [63:0] a,
    input  wire logic signed [32:0] b,
    output pti_pkg::mul_rsp_t       rsp,
    output logic signed [63:0]      result
);

    typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_ACC, M_OUT} mstate_t;

    mstate_t            state_reg;
    logic        [63:0] ma_reg;
    logic        [31:0] mb_reg;
    logic               neg_reg;
    logic               half_reg;
    logic        [63:0] pp_reg;
    logic        [95:0] prod_reg;
    logic signed [63:0] result_reg;
    logic               sat_reg;
    logic               done_reg;

    logic [63:0] a_mag;
    logic [32:0] b_mag;
    logic [31:0] mul_a;
    logic [63:0] pp_next;
    logic [95:0] q;
    logic [95:0] limit;
    logic        over;
    logic [63:0] res_next;

    assign a_mag   = a[63] ? (~a + 64'd1) : a;
    assign b_mag   = b[32] ? (~b + 33'd1) : b;
    assign mul_a   = (state_reg == M_HI) ? ma_reg[63:32] : ma_reg[31:0];
    assign pp_next = mul_a * mb_reg;

    assign q     = half_reg ? (prod_reg >> 25) : (prod_reg >> 24);
    assign limit = {32'd0, (neg_reg ? pti_pkg::Q_MIN : pti_pkg::Q_MAX)};
    assign over  = q > limit;

    always_comb
    begin
        if (over)
            res_next = neg_reg ? pti_pkg::Q_MIN : pti_pkg::Q_MAX;
        else if (neg_reg)
            res_next = ~q[63:0] + 64'd1;
        else
            res_next = q[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            done_reg   <= 1'b0;
            sat_reg    <= 1'b0;
            ma_reg     <= '0;
            mb_reg     <= '0;
            neg_reg    <= 1'b0;
            half_reg   <= 1'b0;
            pp_reg     <= '0;
            prod_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        ma_reg    <= a_mag;
                        mb_reg    <= b_mag[31:0];
                        neg_reg   <= a[63] ^ b[32];
                        half_reg  <= req.half;
                        state_reg <= M_LO;
                    end
                end
                M_LO:
                begin
                    pp_reg    <= pp_next;
                    state_reg <= M_HI;
                end
                M_HI:
                begin
                    prod_reg  <= {32'd0, pp_reg};
                    pp_reg    <= pp_next;
                    state_reg <= M_ACC;
                end
                M_ACC:
                begin
                    prod_reg  <= prod_reg + {pp_reg, 32'd0};
                    state_reg <= M_OUT;
                end
                M_OUT:
                begin
                    result_reg <= res_next;
                    sat_reg    <= over;
                    done_reg   <= 1'b1;
                    state_reg  <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign result   = result_reg;

endmodule

`default_nettype wire

FILE: rtl/polynomial_trapezoid_integrator.sv
// Top level: coefficient registers, sequencer and saturating adder.
// Depends on pti_pkg, pti_div, pti_mul and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A transaction starts on start while busy is low and ends with one result on
// integral/overflow, marked by a single-cycle done pulse that the receiver
// must take when it comes. The step width division comes first; each
// polynomial evaluation is four Horner steps on the shared 32x32
// multiply-shift unit; each interval adds the grid step and the sums in both
// trapezoid and left-rectangle mode; a final scaling ends the job, and zero
// steps count as one. busy stays high for the whole job and falls with done,
// so the next transaction can be accepted while done is high; coefficients
// are to be written through wr_en/wr_index/wr_data only while the block is
// idle, which the block itself does not enforce.
module polynomial_trapezoid_integrator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    input  wire logic               mode,
    input  wire logic signed [31:0] x_left,
    input  wire logic signed [31:0] x_right,
    input  wire logic        [15:0] steps,
    output logic signed [63:0]      integral,
    output logic                    overflow,
    input  wire logic               wr_en,
    input  wire logic [pti_pkg::IDX_W-1:0] wr_index,
    input  wire logic        [31:0] wr_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_MUL, S_MWAIT, S_SUML, S_SUMR, S_STEP, S_FMUL, S_FWAIT
    } state_t;

    state_t             state_reg;
    logic        [31:0] coef_reg [pti_pkg::NUM_COEF];
    logic               mode_reg;
    logic signed [31:0] x_reg;
    logic signed [32:0] h_reg;
    logic        [15:0] cnt_reg;
    logic [pti_pkg::IDX_W-1:0] k_reg;
    logic               first_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] fl_reg;
    logic signed [63:0] sum_reg;
    logic               flag_reg;
    logic               done_reg;
    logic signed [63:0] integral_reg;
    logic               overflow_reg;

    logic               div_start;
    logic signed [32:0] div_dividend;
    logic        [15:0] div_divisor;
    logic               div_done;
    logic signed [32:0] div_quot;

    pti_pkg::mul_req_t  mul_req;
    pti_pkg::mul_rsp_t  mul_rsp;
    logic signed [63:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [63:0] mul_result;

    logic [31:0] coef_k;
    logic [63:0] coef0_q;
    logic [63:0] coefk_q;
    logic [63:0] add_a;
    logic [63:0] add_b;
    logic [63:0] add_sum;
    logic        add_ovf;
    logic [63:0] add_res;
    logic [32:0] x_next;
    logic        accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // step width h = (x_right - x_left) / steps, zero steps counts as one
    assign div_start    = accept;
    assign div_dividend = {x_right[31], x_right} - {x_left[31], x_left};
    assign div_divisor  = (steps == 16'd0) ? 16'd1 : steps;

    pti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign mul_req.start = (state_reg == S_MUL) || (state_reg == S_FMUL);
    assign mul_req.half  = (state_reg == S_FMUL) && (mode_reg == pti_pkg::MODE_TRAP);
    assign mul_a         = (state_reg == S_FMUL) ? sum_reg : acc_reg;
    assign mul_b         = (state_reg == S_FMUL) ? h_reg : {x_reg[31], x_reg};

    pti_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .a      (mul_a),
        .b      (mul_b),
        .rsp    (mul_rsp),
        .result (mul_result)
    );

    // Q16.16 coefficient widened to Q32.32
    assign coef_k  = coef_reg[k_reg];
    assign coef0_q = {{16{coef_reg[0][31]}}, coef_reg[0], 16'd0};
    assign coefk_q = {{16{coef_k[31]}}, coef_k, 16'd0};

    // shared saturating adder: Horner step, then left and right sums
    always_comb
    begin
        case (state_reg)
            S_SUML:
            begin
                add_a = sum_reg;
                add_b = fl_reg;
            end
            S_SUMR:
            begin
                add_a = sum_reg;
                add_b = acc_reg;
            end
            default:
            begin
                add_a = mul_result;
                add_b = coefk_q;
            end
        endcase
    end

    assign add_sum = add_a + add_b;
    assign add_ovf = (add_a[63] == add_b[63]) && (add_sum[63] != add_a[63]);
    assign add_res = add_ovf ? (add_a[63] ? pti_pkg::Q_MIN : pti_pkg::Q_MAX) : add_sum;

    // grid point stays between the bounds, so 32 bits hold it
    assign x_next = {x_reg[31], x_reg} + h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < pti_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= pti_pkg::COEF_RESET[i];
            end
            mode_reg     <= pti_pkg::MODE_TRAP;
            x_reg        <= '0;
            h_reg        <= '0;
            cnt_reg      <= '0;
            k_reg        <= '0;
            first_reg    <= 1'b0;
            acc_reg      <= '0;
            fl_reg       <= '0;
            sum_reg      <= '0;
            flag_reg     <= 1'b0;
            done_reg     <= 1'b0;
            integral_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (wr_en && (wr_index < pti_pkg::COEF_LIMIT))
            begin
                coef_reg[wr_index] <= wr_data;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg  <= mode;
                        x_reg     <= x_left;
                        cnt_reg   <= div_divisor;
                        sum_reg   <= '0;
                        flag_reg  <= 1'b0;
                        first_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        h_reg     <= div_quot;
                        acc_reg   <= coef0_q;
                        k_reg     <= pti_pkg::K_FIRST;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        acc_reg  <= add_res;
                        flag_reg <= flag_reg | mul_rsp.sat | add_ovf;
                        if (k_reg == pti_pkg::K_LAST)
                        begin
                            // polynomial value ready; in trapezoid mode a later
                            // value stays in acc_reg as the right end
                            first_reg <= 1'b0;
                            if (first_reg || (mode_reg == pti_pkg::MODE_RECT))
                                fl_reg <= add_res;
                            if (first_reg && (mode_reg == pti_pkg::MODE_TRAP))
                                state_reg <= S_STEP;
                            else
                                state_reg <= S_SUML;
                        end
                        else
                        begin
                            k_reg     <= k_reg + pti_pkg::IDX_W'(1);
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_SUML:
                begin
                    sum_reg  <= add_res;
                    flag_reg <= flag_reg | add_ovf;
                    if (mode_reg == pti_pkg::MODE_TRAP)
                        state_reg <= S_SUMR;
                    else if (cnt_reg == 16'd1)
                        state_reg <= S_FMUL;
                    else
                    begin
                        cnt_reg   <= cnt_reg - 16'd1;
                        state_reg <= S_STEP;
                    end
                end
                S_SUMR:
                begin
                    sum_reg  <= add_res;
                    flag_reg <= flag_reg | add_ovf;
                    fl_reg   <= acc_reg;
                    if (cnt_reg == 16'd1)
                        state_reg <= S_FMUL;
                    else
                    begin
                        cnt_reg   <= cnt_reg - 16'd1;
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    x_reg     <= x_next[31:0];
                    acc_reg   <= coef0_q;
                    k_reg     <= pti_pkg::K_FIRST;
                    state_reg <= S_MUL;
                end
                S_FMUL:
                begin
                    state_reg <= S_FWAIT;
                end
                S_FWAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        integral_reg <= mul_result;
                        overflow_reg <= flag_reg | mul_rsp.sat;
                        done_reg     <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign integral = integral_reg;
    assign overflow = overflow_reg;

    `PTI_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE)
    `PTI_ASSERT_NXT(a_accept_busy, accept, busy && !done_reg)
    `PTI_ASSERT_IMP(a_mul_awaited, mul_rsp.done, (state_reg == S_MWAIT) || (state_reg == S_FWAIT))
    `PTI_ASSERT_IMP(a_div_awaited, div_done, state_reg == S_DIV)

endmodule

`default_nettype wire
